// ===== hw/rtl/rmms_pkg.sv =====
// Package for the running min/max/mean statistics block.
// Holds the channel payload types, the command codes and the shared sizes.
// No dependencies.
`default_nettype none

package rmms_pkg;

    localparam int unsigned FIELD_BITS     = 32;
    localparam int unsigned VALUE_BITS_DEF = 32;
    localparam int unsigned QUEUE_DEPTH    = 2;
    localparam int unsigned QPTR_BITS      = $clog2(QUEUE_DEPTH);

    typedef enum logic {
        OP_RECORD = 1'b0,
        OP_CLEAR  = 1'b1
    } op_t;

    typedef struct packed {
        logic                  command;
        logic [FIELD_BITS-1:0] sample;
    } in_item_t;

    typedef struct packed {
        logic [FIELD_BITS-1:0] minimum;
        logic [FIELD_BITS-1:0] maximum;
        logic [FIELD_BITS-1:0] mean;
        logic [FIELD_BITS-1:0] sample_count;
        logic                  sum_full;
    } out_item_t;

endpackage

`default_nettype wire

// ===== hw/rtl/rmms_front.sv =====
// Front end of the statistics block: accepts input transfers, decodes the command
// and holds decoded operations in a short queue for the back end.
// Depends on rmms_pkg.
`default_nettype none

module rmms_front
    import rmms_pkg::*;
#(
    parameter int unsigned VALUE_BITS = VALUE_BITS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  in_item_t              s_data,
    output logic                  q_valid,
    input  logic                  q_ready,
    output op_t                   q_op,
    output logic [VALUE_BITS-1:0] q_sample
);

    localparam int unsigned CNT_BITS = $clog2(QUEUE_DEPTH + 1);

    op_t                            op_mem  [QUEUE_DEPTH];
    logic [VALUE_BITS-1:0]          smp_mem [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0]           wr_ptr_reg, wr_ptr_next;
    logic [QPTR_BITS-1:0]           rd_ptr_reg, rd_ptr_next;
    logic [CNT_BITS-1:0]            cnt_reg, cnt_next;
    logic                           push, pop;
    logic [FIELD_BITS+VALUE_BITS-1:0] smp_ext;

    // The sample is fitted to the datapath width: zero-extended or truncated.
    assign smp_ext = {{VALUE_BITS{1'b0}}, s_data.sample};

    assign s_ready  = (cnt_reg != CNT_BITS'(QUEUE_DEPTH));
    assign q_valid  = (cnt_reg != '0);
    assign push     = s_valid && s_ready;
    assign pop      = q_valid && q_ready;
    assign q_op     = op_mem[rd_ptr_reg];
    assign q_sample = smp_mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0
                                                                      : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0
                                                                      : rd_ptr_reg + 1'b1;
        end
        case ({push, pop})
            2'b10:   cnt_next = cnt_reg + 1'b1;
            2'b01:   cnt_next = cnt_reg - 1'b1;
            default: cnt_next = cnt_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            op_mem[wr_ptr_reg]  <= op_t'(s_data.command);
            smp_mem[wr_ptr_reg] <= smp_ext[VALUE_BITS-1:0];
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/rmms_div.sv =====
// Iterative restoring divider with round-half-up correction for the mean.
// One quotient bit per cycle, then a rounding step.
// Depends on rmms_pkg.
`default_nettype none

module rmms_div
    import rmms_pkg::*;
#(
    parameter int unsigned VALUE_BITS = VALUE_BITS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  start,
    input  logic [VALUE_BITS-1:0] dividend,
    input  logic [VALUE_BITS-1:0] divisor,
    output logic                  busy,
    output logic                  done,
    output logic [VALUE_BITS-1:0] quotient
);

    localparam int unsigned CNT_BITS = $clog2(VALUE_BITS);

    localparam logic [1:0] DV_IDLE  = 2'd0;
    localparam logic [1:0] DV_RUN   = 2'd1;
    localparam logic [1:0] DV_ROUND = 2'd2;

    logic [1:0]            st_reg, st_next;
    logic [VALUE_BITS:0]   rem_reg, rem_next;
    logic [VALUE_BITS-1:0] quo_reg, quo_next;
    logic [VALUE_BITS-1:0] dvs_reg, dvs_next;
    logic [CNT_BITS-1:0]   cnt_reg, cnt_next;
    logic                  done_reg, done_next;
    logic [VALUE_BITS:0]   rem_sh;
    logic [VALUE_BITS+1:0] diff;
    logic [VALUE_BITS-1:0] half_thr;

    assign rem_sh   = {rem_reg[VALUE_BITS-1:0], quo_reg[VALUE_BITS-1]};
    assign diff     = {1'b0, rem_sh} - {2'b00, dvs_reg};
    // Round up when the remainder reaches the divisor minus half of it.
    assign half_thr = dvs_reg - (dvs_reg >> 1);

    assign busy     = (st_reg != DV_IDLE);
    assign done     = done_reg;
    assign quotient = quo_reg;

    always_comb begin
        st_next   = st_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        case (st_reg)
            DV_IDLE: begin
                if (start) begin
                    rem_next = '0;
                    quo_next = dividend;
                    dvs_next = divisor;
                    cnt_next = '0;
                    st_next  = DV_RUN;
                end
            end
            DV_RUN: begin
                if (!diff[VALUE_BITS+1]) begin
                    rem_next = diff[VALUE_BITS:0];
                end else begin
                    rem_next = rem_sh;
                end
                quo_next = {quo_reg[VALUE_BITS-2:0], ~diff[VALUE_BITS+1]};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_BITS'(VALUE_BITS - 1)) begin
                    st_next = DV_ROUND;
                end
            end
            DV_ROUND: begin
                if (rem_reg >= {1'b0, half_thr}) begin
                    quo_next = quo_reg + 1'b1;
                end
                done_next = 1'b1;
                st_next   = DV_IDLE;
            end
            default: begin
                st_next = DV_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg   <= DV_IDLE;
            done_reg <= 1'b0;
        end else begin
            st_reg   <= st_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
        cnt_reg <= cnt_next;
    end

endmodule

`default_nettype wire

// ===== hw/rtl/rmms_back.sv =====
// Back end of the statistics block: applies queued operations to the running
// minimum, maximum, sum and count, runs the mean division and drives the result register.
// Depends on rmms_pkg and rmms_div.
`default_nettype none

module rmms_back
    import rmms_pkg::*;
#(
    parameter int unsigned VALUE_BITS = VALUE_BITS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  q_valid,
    output logic                  q_ready,
    input  op_t                   q_op,
    input  logic [VALUE_BITS-1:0] q_sample,
    output logic                  m_valid,
    input  logic                  m_ready,
    output out_item_t             m_data
);

    localparam logic [1:0] BK_IDLE  = 2'd0;
    localparam logic [1:0] BK_START = 2'd1;
    localparam logic [1:0] BK_DIV   = 2'd2;
    localparam logic [1:0] BK_FIN   = 2'd3;

    logic [1:0]            state_reg, state_next;
    logic [VALUE_BITS-1:0] min_reg, min_next;
    logic [VALUE_BITS-1:0] max_reg, max_next;
    logic [VALUE_BITS-1:0] sum_reg, sum_next;
    logic [VALUE_BITS-1:0] count_reg, count_next;
    logic                  full_reg, full_next;
    logic                  mean_zero_reg, mean_zero_next;
    logic                  m_valid_reg, m_valid_next;
    out_item_t             m_data_reg, m_data_next;

    logic                  pop;
    logic                  first;
    logic [VALUE_BITS:0]   sum_add;
    logic                  div_start, div_busy, div_done;
    logic [VALUE_BITS-1:0] div_quot;
    logic [VALUE_BITS-1:0] mean_val;
    logic [VALUE_BITS+FIELD_BITS-1:0] min_ext, max_ext, mean_ext, count_ext;

    rmms_div #(
        .VALUE_BITS(VALUE_BITS)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (sum_reg),
        .divisor  (count_reg),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (div_quot)
    );

    assign q_ready = (state_reg == BK_IDLE);
    assign pop     = q_valid && q_ready;
    assign first   = (count_reg == '0);
    assign sum_add = {1'b0, sum_reg} + {1'b0, q_sample};

    assign mean_val  = mean_zero_reg ? '0 : div_quot;
    // Results are fitted to the 32-bit output fields.
    assign min_ext   = {{FIELD_BITS{1'b0}}, min_reg};
    assign max_ext   = {{FIELD_BITS{1'b0}}, max_reg};
    assign mean_ext  = {{FIELD_BITS{1'b0}}, mean_val};
    assign count_ext = {{FIELD_BITS{1'b0}}, count_reg};

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    always_comb begin
        state_next     = state_reg;
        min_next       = min_reg;
        max_next       = max_reg;
        sum_next       = sum_reg;
        count_next     = count_reg;
        full_next      = full_reg;
        mean_zero_next = mean_zero_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        m_data_next    = m_data_reg;
        div_start      = 1'b0;
        case (state_reg)
            BK_IDLE: begin
                if (pop) begin
                    state_next = BK_START;
                    full_next  = 1'b0;
                    if (q_op == OP_CLEAR) begin
                        min_next   = '0;
                        max_next   = '0;
                        sum_next   = '0;
                        count_next = '0;
                    end else begin
                        if (first || (q_sample < min_reg)) begin
                            min_next = q_sample;
                        end
                        if (first || (q_sample > max_reg)) begin
                            max_next = q_sample;
                        end
                        // A sample that would carry out of the sum skips sum and count.
                        if (!sum_add[VALUE_BITS]) begin
                            sum_next = sum_add[VALUE_BITS-1:0];
                            if (!(&count_reg)) begin
                                count_next = count_reg + 1'b1;
                            end
                        end else begin
                            full_next = 1'b1;
                        end
                    end
                end
            end
            BK_START: begin
                if (first) begin
                    mean_zero_next = 1'b1;
                    state_next     = BK_FIN;
                end else begin
                    mean_zero_next = 1'b0;
                    div_start      = 1'b1;
                    state_next     = BK_DIV;
                end
            end
            BK_DIV: begin
                if (div_done) begin
                    state_next = BK_FIN;
                end
            end
            BK_FIN: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next             = 1'b1;
                    m_data_next.minimum      = min_ext[FIELD_BITS-1:0];
                    m_data_next.maximum      = max_ext[FIELD_BITS-1:0];
                    m_data_next.mean         = mean_ext[FIELD_BITS-1:0];
                    m_data_next.sample_count = count_ext[FIELD_BITS-1:0];
                    m_data_next.sum_full     = full_reg;
                    state_next               = BK_IDLE;
                end
            end
            default: begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= BK_IDLE;
            min_reg       <= '0;
            max_reg       <= '0;
            sum_reg       <= '0;
            count_reg     <= '0;
            full_reg      <= 1'b0;
            mean_zero_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            min_reg       <= min_next;
            max_reg       <= max_next;
            sum_reg       <= sum_next;
            count_reg     <= count_next;
            full_reg      <= full_next;
            mean_zero_reg <= mean_zero_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
    end

    a_empty_sum_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg == '0) |-> (sum_reg == '0))
        else $error("sum is nonzero while no sample is counted");

    a_empty_minmax_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg == '0) |-> ((min_reg == '0) && (max_reg == '0)))
        else $error("min or max is nonzero while statistics are empty");

    a_min_le_max: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg != '0) |-> (min_reg <= max_reg))
        else $error("running minimum exceeds running maximum");

    a_div_start_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        div_start |-> !div_busy)
        else $error("divider started while still busy");

endmodule

`default_nettype wire

// ===== hw/rtl/running_min_max_mean_stats.sv =====
// Top level of the running min/max/mean statistics block.
// Connects the command front end to the statistics back end; depends on rmms_pkg,
// rmms_front, rmms_back and rmms_div.
//
//   Channel   Direction  Handshake          Payload
//   s_        in         s_valid/s_ready    in_item_t  {command, sample}
//   m_        out        m_valid/m_ready    out_item_t {minimum, maximum, mean,
//                                                       sample_count, sum_full}
//
// A record command runs the mean division in the back end (states START, DIV, FIN);
// a clear leaves no sample counted, so the back end skips the division and goes from
// START straight to FIN.
// The front queue holds two commands, so the input takes up to two transfers while the
// back end works or while a result waits in the output register.
// A stalled output holds the back end in its final step; the queue then fills and
// s_ready drops.
// Reset is synchronous on aresetn and zeroes all statistics; no clearing pass is needed.
`default_nettype none

module running_min_max_mean_stats
    import rmms_pkg::*;
#(
    parameter int unsigned VALUE_BITS = VALUE_BITS_DEF
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_item_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_data
);

    logic                  q_valid;
    logic                  q_ready;
    op_t                   q_op;
    logic [VALUE_BITS-1:0] q_sample;

    rmms_front #(
        .VALUE_BITS(VALUE_BITS)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_data   (s_data),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_op     (q_op),
        .q_sample (q_sample)
    );

    rmms_back #(
        .VALUE_BITS(VALUE_BITS)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_op     (q_op),
        .q_sample (q_sample),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
// Testbench for running_min_max_mean_stats: random and directed record/clear commands,
// checked against a statistics predictor kept in the bench. Depends on rmms_pkg and the RTL.
`timescale 1ns / 1ps

module testbench;
    import rmms_pkg::*;

    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 100;
    localparam int RANDOM_ITEMS = 100;

    logic      aclk    = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_item_t  s_data  = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_item_t m_data;

    in_item_t  pending_cmds[$];
    out_item_t expected_stats[$];

    // Statistics as the block should hold them.
    logic [31:0] stat_min;
    logic [31:0] stat_max;
    logic [31:0] stat_sum;
    logic [31:0] stat_count;

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_requests  = 0;
    int hold_served    = 0;
    int hold_left      = 0;
    int fail_count     = 0;

    running_min_max_mean_stats uut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always #2 aclk = ~aclk;

    function automatic out_item_t update_stats(in_item_t cmd);
        out_item_t   res;
        logic [63:0] rounded_sum;
        res = '0;
        if (cmd.command == OP_CLEAR) begin
            stat_min   = '0;
            stat_max   = '0;
            stat_sum   = '0;
            stat_count = '0;
        end else begin
            if (stat_count == 0) begin
                stat_min = cmd.sample;
                stat_max = cmd.sample;
            end else begin
                if (cmd.sample < stat_min) stat_min = cmd.sample;
                if (cmd.sample > stat_max) stat_max = cmd.sample;
            end
            if (32'hFFFF_FFFF - stat_sum >= cmd.sample) begin
                stat_sum = stat_sum + cmd.sample;
                if (stat_count != 32'hFFFF_FFFF) stat_count = stat_count + 1;
            end else begin
                res.sum_full = 1'b1;
            end
        end
        res.minimum      = stat_min;
        res.maximum      = stat_max;
        res.sample_count = stat_count;
        if (stat_count != 0) begin
            // Rounding half up without wrap: the addition is done in 64 bits.
            rounded_sum = {32'b0, stat_sum} + {33'b0, stat_count[31:1]};
            res.mean    = 32'(rounded_sum / {32'b0, stat_count});
        end
        return res;
    endfunction

    // Driver: offers queued commands, predicting each one as its transfer completes.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            stat_min   = '0;
            stat_max   = '0;
            stat_sum   = '0;
            stat_count = '0;
        end else begin
            if (s_valid && s_ready) expected_stats.push_back(update_stats(s_data));
            if (!s_valid || s_ready) begin
                if (pending_cmds.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    s_valid <= 1'b1;
                    s_data  <= pending_cmds.pop_front();
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: checks each result transfer and drives the result-side back-pressure.
    always @(posedge aclk) begin
        out_item_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_stats.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected result: min=%h max=%h mean=%h count=%h full=%b",
                                 m_data.minimum, m_data.maximum, m_data.mean,
                                 m_data.sample_count, m_data.sum_full);
                end else begin
                    want = expected_stats.pop_front();
                    if (m_data.minimum !== want.minimum || m_data.maximum !== want.maximum ||
                        m_data.mean !== want.mean ||
                        m_data.sample_count !== want.sample_count ||
                        m_data.sum_full !== want.sum_full) begin
                        fail_count++;
                        if (fail_count <= 10) begin
                            $display("mismatch: min exp %h got %h, max exp %h got %h",
                                     want.minimum, m_data.minimum,
                                     want.maximum, m_data.maximum);
                            $display("  mean exp %h got %h, count exp %h got %h, full exp %b got %b",
                                     want.mean, m_data.mean,
                                     want.sample_count, m_data.sample_count,
                                     want.sum_full, m_data.sum_full);
                        end
                    end
                end
            end
            if (hold_left > 0) begin
                hold_left <= hold_left - 1;
                m_ready   <= 1'b0;
            end else if (hold_requests != hold_served) begin
                hold_served <= hold_served + 1;
                hold_left   <= HOLD_CYCLES;
                m_ready     <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
            end
        end
    end

    task automatic push_cmd(op_t op, logic [31:0] value);
        in_item_t cmd;
        cmd.command = op;
        cmd.sample  = value;
        pending_cmds.push_back(cmd);
    endtask

    function automatic logic [31:0] pick_sample();
        case ($urandom_range(0, 5))
            0: return $urandom();
            1: return $urandom_range(0, 255);
            2: return 32'hFFFF_FFFF - $urandom_range(0, 15);
            3: return '0;
            4: return 32'h8000_0000 | $urandom();
            default: return $urandom() >> $urandom_range(0, 31);
        endcase
    endfunction

    // Mostly a clear followed by a run of records; now and then a stray clear or a run
    // that carries on from the previous statistics.
    task automatic push_random(int count);
        int pushed;
        int run_len;
        pushed = 0;
        while (pushed < count) begin
            if ($urandom_range(0, 3) != 0) begin
                push_cmd(OP_CLEAR, $urandom());
                pushed++;
            end
            run_len = $urandom_range(1, 30);
            for (int i = 0; i < run_len && pushed < count; i++) begin
                if ($urandom_range(0, 19) == 0) push_cmd(OP_CLEAR, $urandom());
                else push_cmd(OP_RECORD, pick_sample());
                pushed++;
            end
        end
    endtask

    task automatic wait_drained();
        do @(negedge aclk);
        while (pending_cmds.size() != 0 || s_valid || expected_stats.size() != 0);
    endtask

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Empty statistics, first sample zero, a sum that just fits and then overflows.
        push_cmd(OP_CLEAR, 32'h0);
        push_cmd(OP_RECORD, 32'h0);
        push_cmd(OP_RECORD, 32'hFFFF_FFFF);
        push_cmd(OP_RECORD, 32'h1);
        push_cmd(OP_RECORD, 32'h0);
        push_cmd(OP_CLEAR, 32'hFFFF_FFFF);
        push_cmd(OP_RECORD, 32'h8000_0000);
        push_cmd(OP_RECORD, 32'h7FFF_FFFF);
        push_cmd(OP_RECORD, 32'h8000_0000);
        push_cmd(OP_RECORD, 32'hFFFF_FFFF);
        push_cmd(OP_CLEAR, 32'hAAAA_AAAA);
        // Mean rounding: 5 and 6 give 5.5, which rounds up.
        push_cmd(OP_RECORD, 32'd5);
        push_cmd(OP_RECORD, 32'd6);
        push_cmd(OP_RECORD, 32'd7);
        push_cmd(OP_RECORD, 32'd2);
        push_cmd(OP_RECORD, 32'hAAAA_AAAA);
        push_cmd(OP_RECORD, 32'h5555_5555);
        push_cmd(OP_CLEAR, 32'h5555_5555);
        push_cmd(OP_RECORD, 32'hFFFF_FFFF);
        push_cmd(OP_RECORD, 32'hFFFF_FFFF);
        push_cmd(OP_CLEAR, 32'h0);
        wait_drained();

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                    // A long result stall while commands keep coming fills the front queue.
                    hold_requests  = hold_requests + 1;
                end
                1: begin send_idle_pct = 67; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 67; end
                default: begin send_idle_pct = 28; recv_stall_pct = 28; end
            endcase
            push_random(RANDOM_ITEMS);
            wait_drained();
        end

        recv_stall_pct = 0;
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (fail_count == 0 && expected_stats.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    initial begin
        #4ms;
        $display("tb: failure");
        $finish;
    end

endmodule
